>>> rtl/sfed_pkg.sv
// Shared types and constants for the sync-word frame deframer.
`default_nettype none
package sfed_pkg;

	localparam int NumEncodersDefault = 4;
	localparam int SyncLen = 8;
	localparam logic [7:0] SyncEven = 8'hAA;
	localparam logic [7:0] SyncOdd = 8'h55;

	localparam logic [1:0] StatusOk = 2'd0;
	localparam logic [1:0] StatusNoSync = 2'd1;
	localparam logic [1:0] StatusBad = 2'd2;

	localparam int TokDepth = 2;
	localparam int ResDepth = 2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         enc_id;
		logic signed [31:0] enc_count;
		logic [1:0]         frame_status;
		logic [4:0]         sync_offset;
		logic               last_result;
	} out_item_t;

endpackage
`default_nettype wire

>>> rtl/sync_framed_encoder_deframer_core.sv
// Top level of the sync-word frame deframer for encoder counts.
// The input side is a queue: a request (one received byte and its frame_start flag)
// is taken on a clock edge with push high and full low. A frame holds 8 + 1 + 4 * N
// bytes; frame_start puts its byte at position 0, and the last position closes the frame.
// Two frame banks let the next frame fill while the previous one is evaluated; full rises
// only while both banks wait for evaluation.
// The evaluator reads the frame one byte at a time, each byte in a read state and a check
// state: the sync search scans up to frame length + 7 positions, then the status byte is
// checked, and each count is built from four bytes and then emitted as a result.
// The output side is a queue: while empty is low the oldest result is on result, and it
// is taken on an edge with pop high. A stalled receiver fills the two-entry result queue
// and then holds the evaluator, which in turn holds the banks and finally the input.
// The configuration channel writes the expected status byte on cfg_valid and cfg_ready;
// cfg_ready is always high. Reset clears the fill position, the queues and the status
// value; the frame banks are not cleared.
`default_nettype none
module sync_framed_encoder_deframer_core #(
	parameter int NumEncoders = sfed_pkg::NumEncodersDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire sfed_pkg::in_item_t  item,
	output logic                     empty,
	input  wire logic                pop,
	output sfed_pkg::out_item_t      result,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_data
);

	localparam int FrameLen = sfed_pkg::SyncLen + 1 + 4 * NumEncoders;
	localparam int PosW = $clog2(FrameLen);
	localparam int ResW = $bits(sfed_pkg::out_item_t);

	logic                wr_en;
	logic [PosW:0]       wr_addr;
	logic [7:0]          wr_data;
	logic                tok_push;
	logic                tok_bank_in;
	logic                tok_bank_out;
	logic                tok_empty;
	logic                tok_pop;
	logic                frame_done;
	logic                res_full;
	logic                res_push;
	sfed_pkg::out_item_t res_data;
	logic [ResW-1:0]     res_dout;

	assign cfg_ready = 1'b1;
	assign result = sfed_pkg::out_item_t'(res_dout);

	sfed_front #(
		.NumEncoders(NumEncoders)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.tok_push  (tok_push),
		.tok_bank  (tok_bank_in),
		.frame_done(frame_done)
	);

	sfed_fifo #(
		.Width(1),
		.Depth(sfed_pkg::TokDepth)
	) u_tok_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (tok_push),
		.din   (tok_bank_in),
		.full  (),
		.pop   (tok_pop),
		.empty (tok_empty),
		.dout  (tok_bank_out)
	);

	sfed_back #(
		.NumEncoders(NumEncoders)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.tok_empty (tok_empty),
		.tok_bank  (tok_bank_out),
		.tok_pop   (tok_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data),
		.frame_done(frame_done)
	);

	sfed_fifo #(
		.Width(ResW),
		.Depth(sfed_pkg::ResDepth)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_data),
		.full  (res_full),
		.pop   (pop),
		.empty (empty),
		.dout  (res_dout)
	);

endmodule
`default_nettype wire

>>> rtl/sfed_fifo.sv
// Small synchronous queue with registered storage.
`default_nettype none
module sfed_fifo #(
	parameter int Width = 1,
	parameter int Depth = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [Width-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic                  empty,
	output logic [Width-1:0]      dout
);

	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [AddrW-1:0] wr_ptr_q;
	logic [AddrW-1:0] rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/sfed_front.sv
// Front part: accepts received bytes and fills one of two frame banks.
`default_nettype none
module sfed_front #(
	parameter int NumEncoders = sfed_pkg::NumEncodersDefault
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire sfed_pkg::in_item_t   item,
	output logic                      wr_en,
	output logic [$clog2(sfed_pkg::SyncLen + 1 + 4 * NumEncoders):0] wr_addr,
	output logic [7:0]                wr_data,
	output logic                      tok_push,
	output logic                      tok_bank,
	input  wire logic                 frame_done
);

	localparam int FrameLen = sfed_pkg::SyncLen + 1 + 4 * NumEncoders;
	localparam int PosW = $clog2(FrameLen);

	logic [PosW-1:0] fill_q;
	logic            wbank_q;
	logic [1:0]      busy_q;
	logic            accept;
	logic [PosW-1:0] pos;
	logic            complete;

	assign full = (busy_q == 2'd2);
	assign accept = push && !full;
	assign pos = item.frame_start ? '0 : fill_q;
	assign complete = accept && (pos == PosW'(FrameLen - 1));

	assign wr_en = accept;
	assign wr_addr = {wbank_q, pos};
	assign wr_data = item.rx_byte;
	assign tok_push = complete;
	assign tok_bank = wbank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			wbank_q <= 1'b0;
			busy_q <= 2'd0;
		end else begin
			if (accept) begin
				if (complete) begin
					fill_q <= '0;
					wbank_q <= !wbank_q;
				end else begin
					fill_q <= pos + 1'b1;
				end
			end
			case ({complete, frame_done})
				2'b10: busy_q <= busy_q + 1'b1;
				2'b01: busy_q <= busy_q - 1'b1;
				default: busy_q <= busy_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/sfed_back.sv
// Back part: holds the frame banks, finds the sync word and builds the results.
`default_nettype none
module sfed_back #(
	parameter int NumEncoders = sfed_pkg::NumEncodersDefault
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [$clog2(sfed_pkg::SyncLen + 1 + 4 * NumEncoders):0] wr_addr,
	input  wire logic [7:0]           wr_data,
	input  wire logic                 cfg_we,
	input  wire logic [7:0]           cfg_data,
	input  wire logic                 tok_empty,
	input  wire logic                 tok_bank,
	output logic                      tok_pop,
	input  wire logic                 res_full,
	output logic                      res_push,
	output sfed_pkg::out_item_t       res_data,
	output logic                      frame_done
);

	localparam int FrameLen = sfed_pkg::SyncLen + 1 + 4 * NumEncoders;
	localparam int PosW = $clog2(FrameLen);
	localparam int MemDepth = 2 ** (PosW + 1);
	localparam int ScanLen = FrameLen + sfed_pkg::SyncLen - 1;
	localparam int ScanW = $clog2(ScanLen);
	localparam int EncW = (NumEncoders > 1) ? $clog2(NumEncoders) : 1;
	localparam int MatchW = $clog2(sfed_pkg::SyncLen + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN_RD = 4'd1;
	localparam logic [3:0] S_SCAN_CHK = 4'd2;
	localparam logic [3:0] S_STAT_RD = 4'd3;
	localparam logic [3:0] S_STAT_CHK = 4'd4;
	localparam logic [3:0] S_DATA_RD = 4'd5;
	localparam logic [3:0] S_DATA_CHK = 4'd6;
	localparam logic [3:0] S_EMIT = 4'd7;

	logic [7:0]          mem [MemDepth];
	logic [7:0]          rdata_q;
	logic [3:0]          state_q;
	logic [7:0]          status_ok_q;
	logic                bank_q;
	logic [PosW-1:0]     ptr_q;
	logic [PosW-1:0]     ptr_next;
	logic [ScanW-1:0]    scan_q;
	logic [ScanW-1:0]    start;
	logic [MatchW-1:0]   mcnt_q;
	logic [MatchW-1:0]   match_next;
	logic [7:0]          expected;
	logic [PosW-1:0]     offset_q;
	logic [EncW-1:0]     enc_q;
	logic [1:0]          bc_q;
	logic [23:0]         count_q;
	sfed_pkg::out_item_t res_q;
	logic                found;
	logic                scan_last;
	logic                enc_last;
	logic                status_bad;

	assign ptr_next = (ptr_q == PosW'(FrameLen - 1)) ? '0 : ptr_q + 1'b1;
	assign scan_last = (scan_q == ScanW'(ScanLen - 1));
	assign enc_last = (enc_q == EncW'(NumEncoders - 1));
	assign start = scan_q - ScanW'(sfed_pkg::SyncLen - 1);
	assign status_bad = (rdata_q != status_ok_q);

	// The pattern alternates, so a mismatch falls back to one matched byte on 0xAA.
	always_comb begin
		expected = mcnt_q[0] ? sfed_pkg::SyncOdd : sfed_pkg::SyncEven;
		if (rdata_q == expected) begin
			match_next = mcnt_q + 1'b1;
		end else if (rdata_q == sfed_pkg::SyncEven) begin
			match_next = MatchW'(1);
		end else begin
			match_next = '0;
		end
	end
	assign found = (match_next == MatchW'(sfed_pkg::SyncLen));

	assign tok_pop = (state_q == S_IDLE) && !tok_empty;
	assign res_push = (state_q == S_EMIT) && !res_full;
	assign res_data = res_q;
	assign frame_done = res_push && res_q.last_result;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[{bank_q, ptr_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_ok_q <= 8'd0;
		end else begin
			if (cfg_we) begin
				status_ok_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!tok_empty) begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (found) begin
						state_q <= S_STAT_RD;
					end else if (scan_last) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_STAT_RD: state_q <= S_STAT_CHK;
				S_STAT_CHK: state_q <= status_bad ? S_EMIT : S_DATA_RD;
				S_DATA_RD: state_q <= S_DATA_CHK;
				S_DATA_CHK: state_q <= (bc_q == 2'd3) ? S_EMIT : S_DATA_RD;
				S_EMIT: begin
					if (!res_full) begin
						state_q <= res_q.last_result ? S_IDLE : S_DATA_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (!tok_empty) begin
					bank_q <= tok_bank;
					ptr_q <= '0;
					scan_q <= '0;
					mcnt_q <= '0;
				end
			end
			S_SCAN_CHK: begin
				mcnt_q <= match_next;
				ptr_q <= ptr_next;
				scan_q <= scan_q + 1'b1;
				if (found) begin
					offset_q <= start[PosW-1:0];
				end else if (scan_last) begin
					res_q <= '{enc_id: 2'd0, enc_count: 32'sd0,
						frame_status: sfed_pkg::StatusNoSync, sync_offset: 5'd0,
						last_result: 1'b1};
				end
			end
			S_STAT_CHK: begin
				ptr_q <= ptr_next;
				enc_q <= '0;
				bc_q <= 2'd0;
				if (status_bad) begin
					res_q <= '{enc_id: 2'd0, enc_count: 32'sd0,
						frame_status: sfed_pkg::StatusBad,
						sync_offset: 5'(32'(offset_q)), last_result: 1'b1};
				end
			end
			S_DATA_CHK: begin
				count_q <= {count_q[15:0], rdata_q};
				ptr_q <= ptr_next;
				bc_q <= bc_q + 1'b1;
				if (bc_q == 2'd3) begin
					res_q <= '{enc_id: 2'(32'(enc_q)),
						enc_count: {count_q, rdata_q},
						frame_status: sfed_pkg::StatusOk,
						sync_offset: 5'(32'(offset_q)), last_result: enc_last};
				end
			end
			S_EMIT: begin
				if (!res_full && !res_q.last_result) begin
					enc_q <= enc_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> bench/sfed_frame_checker.sv
// Checker that predicts the deframer's results and compares them with the block's output.
`timescale 1ns / 100ps
module sfed_frame_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  sfed_pkg::in_item_t  item,
	input  logic                pop,
	input  logic                empty,
	input  sfed_pkg::out_item_t result,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	output int                  mismatches,
	output int                  outstanding,
	output int                  frames_closed,
	output int                  results_checked
);

	localparam int FrameLen = sfed_pkg::SyncLen + 1 + 4 * sfed_pkg::NumEncodersDefault;

	logic [7:0]          frame_store [FrameLen];
	int unsigned         write_pos;
	logic [7:0]          ok_status;
	sfed_pkg::out_item_t expected_results [$];

	function automatic logic [7:0] store_at(int unsigned pos);
		return frame_store[pos % FrameLen];
	endfunction

	task automatic deframe_byte(sfed_pkg::in_item_t req);
		int unsigned         sync_pos;
		int unsigned         data_pos;
		bit                  hit;
		bit                  same;
		sfed_pkg::out_item_t r;
		if (req.frame_start)
			write_pos = 0;
		frame_store[write_pos] = req.rx_byte;
		write_pos++;
		if (write_pos < FrameLen)
			return;
		write_pos = 0;
		frames_closed++;

		hit = 1'b0;
		sync_pos = 0;
		for (int p = 0; p < FrameLen && !hit; p++) begin
			same = 1'b1;
			for (int k = 0; k < sfed_pkg::SyncLen; k++)
				if (store_at(p + k) != ((k % 2) ? sfed_pkg::SyncOdd : sfed_pkg::SyncEven))
					same = 1'b0;
			if (same) begin
				hit = 1'b1;
				sync_pos = p;
			end
		end

		r = '0;
		r.last_result = 1'b1;
		if (!hit) begin
			r.frame_status = sfed_pkg::StatusNoSync;
			expected_results.push_back(r);
			return;
		end
		r.sync_offset = 5'(sync_pos);
		if (store_at(sync_pos + sfed_pkg::SyncLen) != ok_status) begin
			r.frame_status = sfed_pkg::StatusBad;
			expected_results.push_back(r);
			return;
		end

		data_pos = sync_pos + sfed_pkg::SyncLen + 1;
		for (int e = 0; e < sfed_pkg::NumEncodersDefault; e++) begin
			r.enc_id = 2'(e);
			r.enc_count = {store_at(data_pos + 4 * e), store_at(data_pos + 4 * e + 1),
				store_at(data_pos + 4 * e + 2), store_at(data_pos + 4 * e + 3)};
			r.frame_status = sfed_pkg::StatusOk;
			r.last_result = (e == sfed_pkg::NumEncodersDefault - 1);
			expected_results.push_back(r);
		end
	endtask

	task automatic check_result(sfed_pkg::out_item_t got);
		sfed_pkg::out_item_t want;
		if (expected_results.size() == 0) begin
			$error("Result with no expectation pending: status %0d, offset %0d.",
				got.frame_status, got.sync_offset);
			mismatches++;
			return;
		end
		want = expected_results.pop_front();
		results_checked++;
		if (got.enc_id !== want.enc_id) begin
			$error("enc_id: expected %0d, got %0d", want.enc_id, got.enc_id);
			mismatches++;
		end
		if (got.enc_count !== want.enc_count) begin
			$error("enc_count: expected %h, got %h", want.enc_count, got.enc_count);
			mismatches++;
		end
		if (got.frame_status !== want.frame_status) begin
			$error("frame_status: expected %0d, got %0d", want.frame_status,
				got.frame_status);
			mismatches++;
		end
		if (got.sync_offset !== want.sync_offset) begin
			$error("sync_offset: expected %0d, got %0d", want.sync_offset, got.sync_offset);
			mismatches++;
		end
		if (got.last_result !== want.last_result) begin
			$error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos = 0;
			ok_status = '0;
			expected_results.delete();
			mismatches = 0;
			frames_closed = 0;
			results_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				ok_status = cfg_data;
			if (push && !full)
				deframe_byte(item);
			if (pop && !empty)
				check_result(result);
		end
		outstanding = expected_results.size();
	end

endmodule

>>> bench/tb_sync_framed_encoder_deframer_core.sv
// Testbench top for the sync-word frame deframer: stimulus, idling and the verdict.
`timescale 1ns / 100ps
module tb_sync_framed_encoder_deframer_core;

	localparam int FrameLen = sfed_pkg::SyncLen + 1 + 4 * sfed_pkg::NumEncodersDefault;
	localparam int SettleCycles = 250;
	localparam int HoldCycles = 1500;
	localparam int WatchdogLimit = 6000;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	sfed_pkg::in_item_t  item;
	logic                empty;
	logic                pop;
	sfed_pkg::out_item_t result;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [7:0]          cfg_data;

	int mismatches;
	int outstanding;
	int frames_closed;
	int results_checked;

	int          send_idle_pct;
	int          recv_idle_pct;
	bit          recv_hold;
	int          bytes_sent;
	int          idle_cycles;
	logic [7:0]  status_setting;
	logic [7:0]  frame_buf [FrameLen];

	sync_framed_encoder_deframer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	sfed_frame_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.pop(pop),
		.empty(empty),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.frames_closed(frames_closed),
		.results_checked(results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The receiver either idles at random or, on request, holds off for a long stretch.
	initial begin
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (recv_hold) begin
				pop <= 1'b0;
				repeat (HoldCycles - 1) @(posedge clk);
				recv_hold = 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WatchdogLimit) begin
				$display("Timeout: no request accepted for %0d cycles.", WatchdogLimit);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void fill_frame(logic [7:0] value);
		for (int p = 0; p < FrameLen; p++)
			frame_buf[p] = value;
	endfunction

	function automatic void place_sync(int unsigned at);
		for (int k = 0; k < sfed_pkg::SyncLen; k++)
			frame_buf[(at + k) % FrameLen] = (k % 2) ? sfed_pkg::SyncOdd : sfed_pkg::SyncEven;
	endfunction

	function automatic void put_count(int unsigned at, logic [31:0] value);
		for (int k = 0; k < 4; k++)
			frame_buf[(at + k) % FrameLen] = value[31 - 8 * k -: 8];
	endfunction

	task automatic send_byte(input logic [7:0] value, input logic restart);
		sfed_pkg::in_item_t next;
		next.rx_byte = value;
		next.frame_start = restart;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= next;
		do @(posedge clk); while (full);
		bytes_sent++;
	endtask

	task automatic send_buffer(input logic lead);
		for (int p = 0; p < FrameLen; p++)
			send_byte(frame_buf[p], (p == 0) ? lead : 1'b0);
	endtask

	task automatic write_status(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		status_setting = value;
	endtask

	task automatic drain_and_settle();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Mostly well-formed frames with random content, some with a bad status or a damaged
	// sync word, some pure noise, and now and then an aborted partial frame first.
	task automatic send_random_frame();
		int unsigned at;
		int unsigned kind;
		int unsigned cut;
		logic        lead;
		at = $urandom_range(FrameLen - 1);
		kind = $urandom_range(99);
		lead = 1'($urandom_range(1));
		for (int p = 0; p < FrameLen; p++)
			frame_buf[p] = pick_byte();
		if (kind < 88) begin
			place_sync(at);
			frame_buf[(at + sfed_pkg::SyncLen) % FrameLen] = status_setting;
			if (kind >= 60 && kind < 75)
				frame_buf[(at + sfed_pkg::SyncLen) % FrameLen] ^= 8'(1 << $urandom_range(7));
			else if (kind >= 75)
				frame_buf[(at + $urandom_range(sfed_pkg::SyncLen - 1)) % FrameLen] ^=
					8'(1 << $urandom_range(7));
		end
		if ($urandom_range(99) < 15) begin
			cut = $urandom_range(FrameLen - 1, 1);
			for (int p = 0; p < cut; p++)
				send_byte(pick_byte(), (p == 0) ? 1'($urandom_range(1)) : 1'b0);
			lead = 1'b1;
		end
		send_buffer(lead);
	endtask

	task automatic run_phase(input int sender_pct, input int receiver_pct,
		input logic [7:0] status_value, input int frames, input bit stall);
		drain_and_settle();
		write_status(status_value);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		if (stall)
			recv_hold = 1'b1;
		repeat (frames) send_random_frame();
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		send_idle_pct = 22;
		recv_idle_pct = 66;
		recv_hold = 1'b0;
		bytes_sent = 0;
		idle_cycles = 0;
		status_setting = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_status(8'h00);

		// Sync word at the start of the frame and the extreme counts.
		fill_frame(8'h00);
		place_sync(0);
		put_count(sfed_pkg::SyncLen + 1, 32'h8000_0000);
		put_count(sfed_pkg::SyncLen + 5, 32'h7FFF_FFFF);
		put_count(sfed_pkg::SyncLen + 9, 32'hFFFF_FFFF);
		put_count(sfed_pkg::SyncLen + 13, 32'h0000_0000);
		send_buffer(1'b1);

		// A partial frame that is cut short, then a sync word that wraps past the end.
		for (int p = 0; p < 7; p++)
			send_byte(8'h5A, p == 0);
		fill_frame(8'h11);
		place_sync(FrameLen - 1);
		frame_buf[sfed_pkg::SyncLen - 1] = 8'h00;
		put_count(sfed_pkg::SyncLen, 32'h0123_4567);
		put_count(sfed_pkg::SyncLen + 4, 32'h89AB_CDEF);
		put_count(sfed_pkg::SyncLen + 8, 32'hFEDC_BA98);
		put_count(sfed_pkg::SyncLen + 12, 32'h7654_3210);
		send_buffer(1'b1);

		// A frame that starts without the flag after a full one, with a bad status byte.
		for (int p = 0; p < FrameLen; p++)
			frame_buf[p] = pick_byte();
		place_sync(17);
		frame_buf[0] = 8'h01;
		send_buffer(1'b0);

		// No sync word anywhere in the frame.
		fill_frame(8'hAA);
		send_buffer(1'b0);

		// Good status in the last position, counts wrapping to the front.
		for (int p = 0; p < FrameLen; p++)
			frame_buf[p] = pick_byte();
		place_sync(16);
		frame_buf[FrameLen - 1] = 8'h00;
		send_buffer(1'b1);

		run_phase(22, 66, 8'hFF, 3, 1'b0);
		run_phase(66, 22, 8'($urandom_range(254, 1)), 2, 1'b0);
		run_phase(0, 0, 8'h3C, 3, 1'b1);
		drain_and_settle();

		$display("Sent %0d bytes, closed %0d frames and checked %0d results.",
			bytes_sent, frames_closed, results_checked);
		$display("Covered several status values, idle gaps on both sides and a long stall.");
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
